// ===== src/pdsd_pkg.sv =====
`timescale 1ns / 1ps

package pdsd_pkg;

	// Field and datapath widths.
	localparam int TGT_W      = 20;
	localparam int GAIN_W     = 24;
	localparam int SPD_W      = 16;
	localparam int DLY_W      = 16;
	localparam int POS_W      = 21;
	localparam int TIME_W     = 32;
	localparam int ERR_W      = 22;
	localparam int DIFF_W     = 23;
	localparam int INT_W      = 40;
	localparam int MUL_B_W    = 24;
	localparam int PROD_W     = 48;
	localparam int SUM_W      = 53;
	localparam int ACC_W      = 64;
	localparam int PWR_W      = 8;
	localparam int QUO_W      = 40;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 16;

	// Output saturation limit.
	localparam int POWER_LIMIT = 127;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 3'd6;

	// Configuration reset values.
	localparam logic [GAIN_W-1:0] GAIN_P_RST = 24'd19661;
	localparam logic [GAIN_W-1:0] GAIN_I_RST = 24'd33;
	localparam logic [GAIN_W-1:0] GAIN_D_RST = 24'd65536;
	localparam logic [SPD_W-1:0]  SPEED_RST  = 16'd256;
	localparam logic [DLY_W-1:0]  DELAY_RST  = 16'd350;

	// Datapath operations, one per controller step.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_ABS,
		OP_ERR,
		OP_MUL_P,
		OP_MUL_D,
		OP_MUL_IL,
		OP_MUL_IH,
		OP_ICLAMP,
		OP_SUM,
		OP_MUL_SL,
		OP_MUL_SH,
		OP_FULL
	} dp_op_t;

	// What kind of result the output register gets.
	typedef enum logic [1:0] {
		RES_ZERO,
		RES_HOLD,
		RES_CALC
	} res_kind_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ABS,
		ST_ERR,
		ST_MP,
		ST_MD,
		ST_MIL,
		ST_MIH,
		ST_ICL,
		ST_SUM,
		ST_MSL,
		ST_MSH,
		ST_FULL,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic      capture;
		logic      clear;
		dp_op_t    op;
		logic      out_load;
		res_kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic done;
	} sts_t;

endpackage

// ===== src/pdsd_ctrl.sv =====
`timescale 1ns / 1ps

module pdsd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_start,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  pdsd_pkg::sts_t   sts,
	output pdsd_pkg::cmd_t   cmd
);
	import pdsd_pkg::*;

	ctrl_state_t state_q, state_d;
	res_kind_t   kind_q, kind_d;
	logic        out_valid_q;

	// State, result kind and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= RES_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d      = state_q;
		kind_d       = kind_q;
		cmd.capture  = 1'b0;
		cmd.clear    = 1'b0;
		cmd.op       = OP_NONE;
		cmd.out_load = 1'b0;
		cmd.kind     = kind_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (in_start) begin
						cmd.clear = 1'b1;
						kind_d    = RES_ZERO;
						state_d   = ST_OUT;
					end else if (sts.done) begin
						kind_d  = RES_HOLD;
						state_d = ST_OUT;
					end else begin
						kind_d  = RES_CALC;
						state_d = ST_ABS;
					end
				end
			end
			ST_ABS: begin
				cmd.op  = OP_ABS;
				state_d = ST_ERR;
			end
			ST_ERR: begin
				cmd.op  = OP_ERR;
				state_d = ST_MP;
			end
			ST_MP: begin
				cmd.op  = OP_MUL_P;
				state_d = ST_MD;
			end
			ST_MD: begin
				cmd.op  = OP_MUL_D;
				state_d = ST_MIL;
			end
			ST_MIL: begin
				cmd.op  = OP_MUL_IL;
				state_d = ST_MIH;
			end
			ST_MIH: begin
				cmd.op  = OP_MUL_IH;
				state_d = ST_ICL;
			end
			ST_ICL: begin
				cmd.op  = OP_ICLAMP;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.op  = OP_SUM;
				state_d = ST_MSL;
			end
			ST_MSL: begin
				cmd.op  = OP_MUL_SL;
				state_d = ST_MSH;
			end
			ST_MSH: begin
				cmd.op  = OP_MUL_SH;
				state_d = ST_FULL;
			end
			ST_FULL: begin
				cmd.op  = OP_FULL;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// Wait for the output register to be free.
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== src/pdsd_dpath.sv =====
`timescale 1ns / 1ps

module pdsd_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pdsd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pdsd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [pdsd_pkg::IN_DATA_W-1:0]     in_data,
	output logic [pdsd_pkg::OUT_DATA_W-1:0]    out_data,
	input  pdsd_pkg::cmd_t                     cmd,
	output pdsd_pkg::sts_t                     sts
);
	import pdsd_pkg::*;

	localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
	localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ITERM_MAX = 64'sh0004_0000_0000_0000;
	localparam logic signed [ACC_W-1:0] ITERM_MIN = -ITERM_MAX;
	localparam logic signed [ACC_W-1:0] SUM_MAX   = 64'sh0000_0100_0000_0000;
	localparam logic signed [ACC_W-1:0] SUM_MIN   = -SUM_MAX;
	localparam logic signed [ACC_W-1:0] RND_BIAS  = 64'sd16777215;
	localparam logic signed [QUO_W-1:0] PWR_MAX   = QUO_W'(POWER_LIMIT);
	localparam logic signed [QUO_W-1:0] PWR_MIN   = -PWR_MAX;

	// Configuration registers.
	logic [TGT_W-1:0]  tgt_q;
	logic              reverse_q;
	logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic [SPD_W-1:0]  speed_q;
	logic [DLY_W-1:0]  delay_q;

	// Move state.
	logic signed [INT_W-1:0] integ_q;
	logic signed [ERR_W-1:0] prev_q;
	logic                    pending_q, armed_q, done_q;
	logic [TIME_W-1:0]       check_q;

	// Per-sample working registers.
	logic signed [POS_W-1:0]  pos_q;
	logic [TIME_W-1:0]        now_q;
	logic [POS_W-1:0]         abs_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic                     lo_q, hi_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [ACC_W-1:0]  iacc_q;
	logic [PWR_W-1:0]         drive_q;
	logic                     settled_q;

	// Combinational intermediates.
	logic [GAIN_W-1:0]          mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W:0]     mul_full;
	logic signed [ERR_W-1:0]    err_nx;
	logic signed [INT_W:0]      int_add;
	logic signed [INT_W-1:0]    int_sat;
	logic [27:0]                abs100, tgt99, tgt101;
	logic signed [ACC_W-1:0]    prod64, iterm_raw, iterm_cl, sum_raw, sum_cl;
	logic signed [ACC_W-1:0]    biased;
	logic signed [QUO_W-1:0]    quo, quo_dir;
	logic [PWR_W-1:0]           power;
	logic                       fire, done_nx, settle_upd;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q     <= '0;
			reverse_q <= 1'b0;
			gain_p_q  <= GAIN_P_RST;
			gain_i_q  <= GAIN_I_RST;
			gain_d_q  <= GAIN_D_RST;
			speed_q   <= SPEED_RST;
			delay_q   <= DELAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TARGET:  tgt_q     <= cfg_data[TGT_W-1:0];
				CFG_REVERSE: reverse_q <= cfg_data[0];
				CFG_GAIN_P:  gain_p_q  <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_I:  gain_i_q  <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_D:  gain_d_q  <= cfg_data[GAIN_W-1:0];
				CFG_SPEED:   speed_q   <= cfg_data[SPD_W-1:0];
				CFG_DELAY:   delay_q   <= cfg_data[DLY_W-1:0];
				default: ;
			endcase
		end
	end

	// Shared multiplier operand selection: unsigned gain or scale times a signed value.
	always_comb begin
		mul_a = gain_p_q;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_P: begin
				mul_a = gain_p_q;
				mul_b = {{(MUL_B_W-ERR_W){err_q[ERR_W-1]}}, err_q};
			end
			OP_MUL_D: begin
				mul_a = gain_d_q;
				mul_b = {{(MUL_B_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
			end
			OP_MUL_IL: begin
				mul_a = gain_i_q;
				mul_b = {4'b0, integ_q[19:0]};
			end
			OP_MUL_IH: begin
				mul_a = gain_i_q;
				mul_b = {{4{integ_q[INT_W-1]}}, integ_q[INT_W-1:20]};
			end
			OP_MUL_SL: begin
				mul_a = {{(GAIN_W-SPD_W){1'b0}}, speed_q};
				mul_b = {3'b0, sum_q[20:0]};
			end
			OP_MUL_SH: begin
				mul_a = {{(GAIN_W-SPD_W){1'b0}}, speed_q};
				mul_b = {{3{sum_q[41]}}, sum_q[41:21]};
			end
			default: ;
		endcase
		mul_full = $signed({1'b0, mul_a}) * mul_b;
	end

	// Error, integral and window comparisons.
	always_comb begin
		err_nx  = $signed({2'b0, tgt_q}) - $signed({1'b0, abs_q});
		int_add = {integ_q[INT_W-1], integ_q} + {{(INT_W+1-ERR_W){err_nx[ERR_W-1]}}, err_nx};
		if (int_add[INT_W] != int_add[INT_W-1]) begin
			int_sat = int_add[INT_W] ? INT_MIN : INT_MAX;
		end else begin
			int_sat = int_add[INT_W-1:0];
		end
		abs100 = 28'(abs_q) * 28'd100;
		tgt99  = 28'(tgt_q) * 28'd99;
		tgt101 = 28'(tgt_q) * 28'd101;
	end

	// Integral term assembly and PID sum clamps.
	always_comb begin
		prod64    = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
		iterm_raw = iacc_q + (prod64 <<< 20);
		if (iterm_raw > ITERM_MAX) begin
			iterm_cl = ITERM_MAX;
		end else if (iterm_raw < ITERM_MIN) begin
			iterm_cl = ITERM_MIN;
		end else begin
			iterm_cl = iterm_raw;
		end
		sum_raw = {{(ACC_W-SUM_W){sum_q[SUM_W-1]}}, sum_q} + iacc_q;
		if (sum_raw > SUM_MAX) begin
			sum_cl = SUM_MAX;
		end else if (sum_raw < SUM_MIN) begin
			sum_cl = SUM_MIN;
		end else begin
			sum_cl = sum_raw;
		end
	end

	// Scale down by 2^24 rounding toward zero, apply direction, saturate.
	always_comb begin
		biased  = iacc_q + (iacc_q[ACC_W-1] ? RND_BIAS : 64'sd0);
		quo     = biased[ACC_W-1:24];
		quo_dir = reverse_q ? -quo : quo;
		if (quo_dir > PWR_MAX) begin
			power = PWR_MAX[PWR_W-1:0];
		end else if (quo_dir < PWR_MIN) begin
			power = PWR_MIN[PWR_W-1:0];
		end else begin
			power = quo_dir[PWR_W-1:0];
		end
	end

	// Settle check: the sum of time and delay is taken one bit wider.
	assign fire       = armed_q && ({1'b0, now_q} > ({1'b0, check_q} + 33'(delay_q)));
	assign done_nx    = fire && lo_q && hi_q;
	assign settle_upd = cmd.out_load && (cmd.kind == RES_CALC);

	// Move state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q   <= '0;
			prev_q    <= '0;
			pending_q <= 1'b1;
			armed_q   <= 1'b0;
			check_q   <= '0;
			done_q    <= 1'b0;
		end else if (cmd.clear) begin
			integ_q   <= '0;
			prev_q    <= '0;
			pending_q <= 1'b1;
			armed_q   <= 1'b0;
			check_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			if (cmd.op == OP_ERR) begin
				integ_q <= (abs_q != '0) ? int_sat : '0;
			end
			if (cmd.op == OP_MUL_P) begin
				prev_q <= err_q;
			end
			if (settle_upd) begin
				if (pending_q && lo_q) begin
					check_q   <= now_q;
					pending_q <= 1'b0;
					armed_q   <= 1'b1;
				end else if (fire) begin
					if (lo_q && hi_q) begin
						done_q <= 1'b1;
					end else begin
						check_q <= now_q;
					end
				end
			end
		end
	end

	// Working registers, one operation per step.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_q <= in_data[POS_W-1:0];
			now_q <= in_data[POS_W+TIME_W-1:POS_W];
		end
		prod_q <= mul_full[PROD_W-1:0];
		case (cmd.op)
			OP_ABS: begin
				abs_q <= pos_q[POS_W-1] ? (~pos_q + 1'b1) : pos_q;
			end
			OP_ERR: begin
				err_q <= err_nx;
				lo_q  <= abs100 > tgt99;
				hi_q  <= abs100 < tgt101;
			end
			OP_MUL_P: begin
				diff_q <= {err_q[ERR_W-1], err_q} - {prev_q[ERR_W-1], prev_q};
			end
			OP_MUL_D: begin
				sum_q <= {{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
			end
			OP_MUL_IL: begin
				sum_q <= sum_q + {{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
			end
			OP_MUL_IH: begin
				iacc_q <= prod64;
			end
			OP_ICLAMP: begin
				iacc_q <= iterm_cl;
			end
			OP_SUM: begin
				sum_q <= sum_cl[SUM_W-1:0];
			end
			OP_MUL_SH: begin
				iacc_q <= prod64;
			end
			OP_FULL: begin
				iacc_q <= iacc_q + (prod64 <<< 21);
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.kind)
				RES_ZERO: begin
					drive_q   <= '0;
					settled_q <= 1'b0;
				end
				RES_HOLD: begin
					drive_q   <= '0;
					settled_q <= 1'b1;
				end
				RES_CALC: begin
					drive_q   <= done_nx ? '0 : power;
					settled_q <= done_nx;
				end
				default: begin
					drive_q   <= '0;
					settled_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_data = {{(OUT_DATA_W-PWR_W-1){1'b0}}, settled_q, drive_q};
	assign sts.done = done_q;

endmodule

// ===== src/pid_drive_with_settle_detect.sv =====
// Flow: a sample beat steps through the absolute value, error, P, D, integral, clamp,
// sum and scaling states before its result is loaded; a start marker or a sample after
// settling goes straight to loading. No new sample is taken until the result is loaded,
// and the P, D, integral and scaling products all go through the shared 24x24 multiplier.
// Reset: arst_n clears the move state and loads the default gains, scale and delay.
`timescale 1ns / 1ps

module pid_drive_with_settle_detect (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pdsd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pdsd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// s_axis_tdata: encoder_pos [20:0], now_ms [52:21], zero pad [55:53]
	input  logic [pdsd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// s_axis_tuser: start_move
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// m_axis_tdata: drive_power [7:0], settled [8], zero pad [15:9]
	output logic [pdsd_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
	import pdsd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	pdsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_start  (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Arithmetic, configuration and move state.
	pdsd_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.out_data  (m_axis_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

`ifndef ASSERT_OFF
	// After a beat is taken the controller is not ready in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted twice in a row");

	// A start marker clears the settled state.
	a_start_clears_done: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !sts.done)
		else $error("settled state survived a start marker");

	// A result is only loaded into a free or draining output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("pending output beat overwritten");
`endif

endmodule

// ===== bench/tb_pid_drive_with_settle_detect.sv =====
`timescale 1ns / 1ps

module tb_pid_drive_with_settle_detect;
	import pdsd_pkg::*;

	// One motor command as it leaves the block.
	typedef struct packed {
		logic signed [PWR_W-1:0] power;
		logic                    settled;
	} drive_t;

	// One directed beat, with a hand-typed command where it is obvious.
	typedef struct packed {
		logic              start;
		logic [POS_W-1:0]  pos;
		logic [TIME_W-1:0] now;
		logic              typed;
		logic [PWR_W-1:0]  power;
		logic              settled;
	} dir_row_t;

	localparam int     DIR_ROWS     = 19;
	localparam int     DIR_RETARGET = 3;
	localparam int     NUM_PHASES   = 12;
	localparam int     PHASE_ITEMS  = 136;
	localparam longint INTEG_HI     = 64'sd549755813887;
	localparam longint INTEG_LO     = -64'sd549755813888;
	localparam longint ITERM_LIM    = 64'sd1 <<< 50;
	localparam longint SUM_LIM      = 64'sd1 <<< 40;
	localparam longint SCALE_DIV    = 64'sd1 <<< 24;

	// Directed rows: reset state, field extremes, a full settle, time wrap.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{1'b0, 21'd0,        32'd0,          1'b1, 8'h00, 1'b0},
		'{1'b0, 21'd1048575,  32'hFFFFFFFF,   1'b1, 8'h81, 1'b0},
		'{1'b0, 21'h100000,   32'd0,          1'b1, 8'h81, 1'b0},
		'{1'b1, 21'h1ABCDE,   32'h12345678,   1'b1, 8'h00, 1'b0},
		'{1'b0, 21'd0,        32'd0,          1'b0, 8'h00, 1'b0},
		'{1'b0, 21'd500,      32'd20,         1'b0, 8'h00, 1'b0},
		'{1'b0, -21'sd995,    32'd40,         1'b0, 8'h00, 1'b0},
		'{1'b0, 21'd1020,     32'd400,        1'b0, 8'h00, 1'b0},
		'{1'b0, 21'd1005,     32'd700,        1'b0, 8'h00, 1'b0},
		'{1'b0, 21'd1009,     32'd751,        1'b1, 8'h00, 1'b1},
		'{1'b0, -21'sd50000,  32'd800,        1'b1, 8'h00, 1'b1},
		'{1'b1, 21'd0,        32'd0,          1'b1, 8'h00, 1'b0},
		'{1'b0, 21'd990,      32'd10,         1'b0, 8'h00, 1'b0},
		'{1'b0, 21'd991,      32'd4294967000, 1'b0, 8'h00, 1'b0},
		'{1'b0, 21'd1000,     32'hFFFFFFFF,   1'b0, 8'h00, 1'b0},
		'{1'b0, 21'd1000,     32'd5,          1'b0, 8'h00, 1'b0},
		'{1'b0, 21'd1048575,  32'd100,        1'b0, 8'h00, 1'b0},
		'{1'b1, 21'h0F0F0F,   32'hA5A5A5A5,   1'b1, 8'h00, 1'b0},
		'{1'b0, 21'h100000,   32'd0,          1'b0, 8'h00, 1'b0}
	};

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// Mirror of the configuration registers.
	logic [TGT_W-1:0]  m_target  = '0;
	logic              m_reverse = 1'b0;
	logic [GAIN_W-1:0] m_gain_p  = GAIN_P_RST;
	logic [GAIN_W-1:0] m_gain_i  = GAIN_I_RST;
	logic [GAIN_W-1:0] m_gain_d  = GAIN_D_RST;
	logic [SPD_W-1:0]  m_speed   = SPEED_RST;
	logic [DLY_W-1:0]  m_delay   = DELAY_RST;

	// Mirror of the move state.
	longint integ_acc   = 0;
	longint last_err    = 0;
	bit     await_pass  = 1'b1;
	bit     armed       = 1'b0;
	longint next_check  = 0;
	bit     move_done   = 1'b0;

	drive_t pending_drive [$];
	int     fails = 0;
	bit     calm  = 1'b0;

	pid_drive_with_settle_detect DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("tb_pid_drive_with_settle_detect failed");
		$finish;
	end

	function automatic longint clamp_val(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Computes the command for one beat and advances the mirrored move state.
	function automatic drive_t predict_drive(logic start, logic signed [POS_W-1:0] pos,
			logic [TIME_W-1:0] now);
		longint abs_pos, tgt, err, pterm, iterm, dterm, sum, power, t;
		drive_t r;
		r = '{power: '0, settled: 1'b0};
		if (start) begin
			integ_acc  = 0;
			last_err   = 0;
			await_pass = 1'b1;
			armed      = 1'b0;
			next_check = 0;
			move_done  = 1'b0;
			return r;
		end
		if (move_done) begin
			r.settled = 1'b1;
			return r;
		end
		abs_pos = (pos < 0) ? -longint'(pos) : longint'(pos);
		tgt     = longint'(m_target);
		t       = longint'(now);
		err     = tgt - abs_pos;

		// The integral only runs once the robot has moved off the start.
		if (err < tgt)
			integ_acc = clamp_val(integ_acc + err, INTEG_LO, INTEG_HI);
		else
			integ_acc = 0;

		pterm    = longint'(m_gain_p) * err;
		iterm    = clamp_val(longint'(m_gain_i) * integ_acc, -ITERM_LIM, ITERM_LIM);
		dterm    = longint'(m_gain_d) * (err - last_err);
		last_err = err;
		sum      = clamp_val(pterm + iterm + dterm, -SUM_LIM, SUM_LIM);
		power    = (sum * longint'(m_speed)) / SCALE_DIV;
		if (m_reverse)
			power = -power;
		power = clamp_val(power, -POWER_LIMIT, POWER_LIMIT);

		// Settle detection: arm on the first pass of 99%, then poll the window.
		if (await_pass && abs_pos * 100 > tgt * 99) begin
			next_check = t;
			await_pass = 1'b0;
			armed      = 1'b1;
		end
		if (armed && t > next_check + longint'(m_delay)) begin
			if (abs_pos * 100 > tgt * 99 && abs_pos * 100 < tgt * 101)
				move_done = 1'b1;
			else
				next_check = t;
		end

		if (move_done)
			r.settled = 1'b1;
		else
			r.power = power[PWR_W-1:0];
		return r;
	endfunction

	// Writes one register at the current edge and keeps the mirror in step.
	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_TARGET:  m_target  = val[TGT_W-1:0];
			CFG_REVERSE: m_reverse = val[0];
			CFG_GAIN_P:  m_gain_p  = val[GAIN_W-1:0];
			CFG_GAIN_I:  m_gain_i  = val[GAIN_W-1:0];
			CFG_GAIN_D:  m_gain_d  = val[GAIN_W-1:0];
			CFG_SPEED:   m_speed   = val[SPD_W-1:0];
			CFG_DELAY:   m_delay   = val[DLY_W-1:0];
			default: ;
		endcase
	endtask

	// Sends one beat after a random gap and records the command it should give.
	task automatic send_beat(logic start, logic [POS_W-1:0] pos, logic [TIME_W-1:0] now,
			logic typed, drive_t fixed);
		int gap;
		drive_t guess;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, now, pos};
		s_axis_tuser  <= start;
		do
			@(posedge clk);
		while (!s_axis_tready);
		guess = predict_drive(start, $signed(pos), now);
		pending_drive.push_back(typed ? fixed : guess);
	endtask

	// Stops the input side and waits until every command has come back.
	task automatic drain(int settle_cycles);
		s_axis_tvalid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (settle_cycles) @(posedge clk);
	endtask

	// Output side: random back-pressure, then a field-by-field check.
	initial begin : drive_monitor
		int     stall;
		drive_t want;
		drive_t got;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_axis_tvalid);
			got.power   = m_axis_tdata[PWR_W-1:0];
			got.settled = m_axis_tdata[PWR_W];
			if (pending_drive.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual power %0d settled %0b",
					$time, got.power, got.settled);
				fails++;
			end else begin
				want = pending_drive.pop_front();
				if (got.power !== want.power) begin
					$display("%0t: drive_power mismatch, expected %0d, actual %0d",
						$time, want.power, got.power);
					fails++;
				end
				if (got.settled !== want.settled) begin
					$display("%0t: settled mismatch, expected %0b, actual %0b",
						$time, want.settled, got.settled);
					fails++;
				end
			end
		end
	end

	// Stimulus: reset, directed rows, then randomized moves under many settings.
	initial begin : stimulus
		int               i;
		int               p;
		int               n;
		int               roll;
		int               tgt;
		int               span;
		int               mv_dist;
		bit               mv_neg;
		logic [TIME_W-1:0] mv_time;
		logic [POS_W-1:0] pos;
		logic [TIME_W-1:0] now;
		logic             start;
		drive_t           none;

		none    = '{power: '0, settled: 1'b0};
		mv_dist = 0;
		mv_neg  = 1'b0;
		mv_time = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed part; the target moves off zero after the reset rows.
		for (i = 0; i < DIR_ROWS; i++) begin
			if (i == DIR_RETARGET) begin
				drain(16);
				write_cfg(CFG_TARGET, 24'd1000);
				cfg_we <= 1'b0;
			end
			send_beat(dir_rows[i].start, dir_rows[i].pos, dir_rows[i].now, dir_rows[i].typed,
				'{power: dir_rows[i].power, settled: dir_rows[i].settled});
		end

		for (p = 0; p < NUM_PHASES; p++) begin
			drain(16);

			// New settings for this phase, extremes in the first few.
			case (p)
				0: begin
					write_cfg(CFG_TARGET, 24'd1000);
					write_cfg(CFG_REVERSE, 24'd0);
					write_cfg(CFG_GAIN_P, GAIN_P_RST);
					write_cfg(CFG_GAIN_I, GAIN_I_RST);
					write_cfg(CFG_GAIN_D, GAIN_D_RST);
					write_cfg(CFG_SPEED, 24'(SPEED_RST));
					write_cfg(CFG_DELAY, 24'd60);
				end
				1: begin
					write_cfg(CFG_TARGET, 24'hFFFFF);
					write_cfg(CFG_REVERSE, 24'd1);
					write_cfg(CFG_GAIN_P, 24'hFFFFFF);
					write_cfg(CFG_GAIN_I, 24'hFFFFFF);
					write_cfg(CFG_GAIN_D, 24'hFFFFFF);
					write_cfg(CFG_SPEED, 24'hFFFF);
					write_cfg(CFG_DELAY, 24'd0);
				end
				2: begin
					write_cfg(CFG_TARGET, 24'($urandom_range(100, 50000)));
					write_cfg(CFG_REVERSE, 24'd0);
					write_cfg(CFG_GAIN_P, 24'd0);
					write_cfg(CFG_GAIN_I, 24'd0);
					write_cfg(CFG_GAIN_D, 24'd0);
					write_cfg(CFG_SPEED, 24'd0);
					write_cfg(CFG_DELAY, 24'hFFFF);
				end
				3: begin
					write_cfg(CFG_TARGET, 24'd0);
					write_cfg(CFG_REVERSE, 24'($urandom_range(0, 1)));
					write_cfg(CFG_GAIN_P, 24'($urandom));
					write_cfg(CFG_GAIN_I, 24'($urandom_range(0, 4096)));
					write_cfg(CFG_GAIN_D, 24'($urandom));
					write_cfg(CFG_SPEED, 24'($urandom_range(0, 2048)));
					write_cfg(CFG_DELAY, 24'($urandom_range(0, 100)));
				end
				default: begin
					if ($urandom_range(0, 4) == 0)
						write_cfg(CFG_TARGET, 24'($urandom_range(0, 1048575)));
					else
						write_cfg(CFG_TARGET, 24'($urandom_range(50, 200000)));
					write_cfg(CFG_REVERSE, 24'($urandom_range(0, 1)));
					write_cfg(CFG_GAIN_P, 24'($urandom_range(0, 1 << 20)));
					write_cfg(CFG_GAIN_I, 24'($urandom_range(0, 4096)));
					write_cfg(CFG_GAIN_D, 24'($urandom_range(0, 1 << 18)));
					write_cfg(CFG_SPEED, 24'($urandom_range(0, 1024)));
					write_cfg(CFG_DELAY, 24'($urandom_range(0, 120)));
				end
			endcase
			cfg_we <= 1'b0;
			tgt = int'(m_target);

			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					calm = ($urandom_range(0, 3) == 0);
				roll  = $urandom_range(0, 99);
				start = 1'b0;
				if (n == 0 || roll < 5) begin
					// Start marker with junk in the sample fields.
					start   = 1'b1;
					pos     = POS_W'($urandom);
					now     = $urandom;
					mv_dist = 0;
					mv_neg  = $urandom_range(0, 1);
					mv_time = ($urandom_range(0, 7) == 0) ? TIME_W'($urandom) :
						TIME_W'($urandom_range(0, 100000));
				end else if (roll < 15) begin
					// Noise: any encoder value at any time.
					pos = POS_W'($urandom);
					now = $urandom;
				end else begin
					// Well-formed sample closing in on the target with jitter.
					if ($urandom_range(0, 19) == 0)
						mv_time = mv_time + TIME_W'($urandom_range(100, 2000));
					else
						mv_time = mv_time + TIME_W'($urandom_range(1, 40));
					span    = tgt / 50 + 1;
					mv_dist = mv_dist + (tgt - mv_dist) / int'($urandom_range(2, 4))
						+ int'($urandom_range(0, span)) - span / 2;
					if (mv_dist < 0)
						mv_dist = 0;
					if (mv_dist > 1048575)
						mv_dist = mv_neg ? 1048576 : 1048575;
					pos = mv_neg ? POS_W'(-mv_dist) : POS_W'(mv_dist);
					now = mv_time;
				end
				send_beat(start, pos, now, 1'b0, none);
			end
		end

		calm = 1'b0;
		drain(30);
		if (fails == 0)
			$display("tb_pid_drive_with_settle_detect passed");
		else
			$display("tb_pid_drive_with_settle_detect failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/pdsd_pkg.sv
src/pdsd_ctrl.sv
src/pdsd_dpath.sv
src/pid_drive_with_settle_detect.sv
bench/tb_pid_drive_with_settle_detect.sv
